>>> src/eoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eoc_pkg
// Shared types, constants and helpers of the elevator order controller.
// ----------------------------------------------------------------------------
package eoc_pkg;

	// building geometry
	localparam int FLOOR_COUNT  = 4;
	localparam int BUTTON_KINDS = 3;
	localparam int ORDER_W      = 12;
	localparam int FLOOR_W      = 2;
	localparam int HOLD_W       = 10;

	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(100);

	// motor and travel directions
	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// controller modes, one-hot
	typedef enum logic [5:0] {
		MODE_HOMING     = 6'b000001,
		MODE_RUN        = 6'b000010,
		MODE_SERVE_HOLD = 6'b000100,
		MODE_OBSTRUCTED = 6'b001000,
		MODE_OBSTR_HOLD = 6'b010000,
		MODE_STOPPED    = 6'b100000
	} mode_t;

	// controller state carried from tick to tick
	typedef struct packed {
		logic [ORDER_W-1:0] pending;
		logic [FLOOR_W-1:0] recent_floor;
		dir_t               travel_dir;
		dir_t               prev_dir;
		dir_t               motor;
		logic               emergency;
		mode_t              mode;
		logic [HOLD_W-1:0]  hold_count;
	} ctrl_state_t;

	// one input tick
	typedef struct packed {
		logic               at_floor;
		logic [FLOOR_W-1:0] floor_index;
		logic [ORDER_W-1:0] call_buttons;
		logic               obstruction;
		logic               stop_button;
	} tick_t;

	// one result item
	typedef struct packed {
		dir_t               motor_command;
		logic [ORDER_W-1:0] button_lamps;
		logic               door_lamp;
		logic               stop_lamp;
		logic [FLOOR_W-1:0] floor_indicator;
	} result_t;

	// order bits that belong to one floor
	function automatic logic [ORDER_W-1:0] floor_mask(input int f);
		logic [ORDER_W-1:0] m;
		int bit_idx;
		m = '0;
		for (int b = 0; b < BUTTON_KINDS; b++) begin
			bit_idx = f * BUTTON_KINDS + b;
			if (bit_idx < ORDER_W)
				m[bit_idx] = 1'b1;
		end
		return m;
	endfunction

	// all order bits that map onto real floors
	function automatic logic [ORDER_W-1:0] order_mask();
		logic [ORDER_W-1:0] m;
		m = '0;
		for (int f = 0; f < FLOOR_COUNT; f++)
			m = m | floor_mask(f);
		return m;
	endfunction

endpackage
`default_nettype wire

>>> src/eoc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eoc_step
// Next-state and result logic for one polling tick: mode handling, call
// latching and the ascending floor scan that picks the motor direction.
// ----------------------------------------------------------------------------
module eoc_step (
	input  eoc_pkg::ctrl_state_t             cur,
	input  eoc_pkg::tick_t                   tick,
	input  logic [eoc_pkg::HOLD_W-1:0]       hold_ticks,
	output eoc_pkg::ctrl_state_t             nxt,
	output eoc_pkg::result_t                 res
);

	logic                          seen;
	logic [eoc_pkg::ORDER_W-1:0]   calls;

	// sanitize the sensor and the buttons
	assign seen  = tick.at_floor && (int'(tick.floor_index) < eoc_pkg::FLOOR_COUNT);
	assign calls = tick.call_buttons & eoc_pkg::order_mask();

	always_comb begin
		logic door;
		logic slamp;
		logic served;
		door   = 1'b0;
		slamp  = 1'b0;
		served = 1'b0;
		nxt    = cur;

		case (cur.mode)
			eoc_pkg::MODE_HOMING: begin
				if (seen && tick.floor_index != '0)
					nxt.motor = eoc_pkg::DIR_DOWN;
				if (seen && tick.floor_index == '0) begin
					nxt.motor = eoc_pkg::DIR_STOP;
					nxt.mode  = eoc_pkg::MODE_RUN;
				end
			end
			eoc_pkg::MODE_SERVE_HOLD: begin
				nxt.pending = cur.pending | calls;
				door = 1'b1;
				if (cur.hold_count <= eoc_pkg::HOLD_W'(1)) begin
					nxt.hold_count = '0;
					nxt.mode       = eoc_pkg::MODE_RUN;
				end else begin
					nxt.hold_count = cur.hold_count - eoc_pkg::HOLD_W'(1);
				end
			end
			eoc_pkg::MODE_OBSTRUCTED: begin
				nxt.pending = cur.pending | calls;
				door  = 1'b1;
				slamp = 1'b1;
				if (!tick.obstruction) begin
					nxt.mode       = eoc_pkg::MODE_OBSTR_HOLD;
					nxt.hold_count = hold_ticks;
				end
			end
			eoc_pkg::MODE_OBSTR_HOLD: begin
				nxt.pending = cur.pending | calls;
				door  = 1'b1;
				slamp = 1'b1;
				if (cur.hold_count <= eoc_pkg::HOLD_W'(1)) begin
					nxt.hold_count = '0;
					nxt.mode       = eoc_pkg::MODE_RUN;
				end else begin
					nxt.hold_count = cur.hold_count - eoc_pkg::HOLD_W'(1);
				end
			end
			eoc_pkg::MODE_STOPPED: begin
				if (tick.stop_button) begin
					nxt.travel_dir = eoc_pkg::DIR_STOP;
					nxt.emergency  = 1'b1;
					nxt.motor      = eoc_pkg::DIR_STOP;
					nxt.pending    = '0;
					slamp = 1'b1;
					door  = seen;
				end else begin
					nxt.mode = eoc_pkg::MODE_RUN;
				end
			end
			default: begin
				// running: latch, then scan floors bottom up
				nxt.mode = eoc_pkg::MODE_RUN;
				if (seen)
					nxt.recent_floor = tick.floor_index;
				nxt.pending = cur.pending | calls;
				// every button of a floor acts the same, so one step per floor
				for (int f = 0; f < eoc_pkg::FLOOR_COUNT; f++) begin
					if (!served && |(nxt.pending & eoc_pkg::floor_mask(f))) begin
						if (nxt.recent_floor < eoc_pkg::FLOOR_W'(f) && !tick.obstruction
								&& nxt.travel_dir != eoc_pkg::DIR_DOWN) begin
							nxt.travel_dir = eoc_pkg::DIR_UP;
							nxt.prev_dir   = eoc_pkg::DIR_UP;
							nxt.motor      = eoc_pkg::DIR_UP;
						end
						if (nxt.recent_floor > eoc_pkg::FLOOR_W'(f) && !tick.obstruction
								&& nxt.travel_dir != eoc_pkg::DIR_UP) begin
							nxt.travel_dir = eoc_pkg::DIR_DOWN;
							nxt.prev_dir   = eoc_pkg::DIR_DOWN;
							nxt.motor      = eoc_pkg::DIR_DOWN;
						end
						if (seen && tick.floor_index == eoc_pkg::FLOOR_W'(f)) begin
							// serve this floor and open the door
							nxt.pending    = nxt.pending & ~eoc_pkg::floor_mask(f);
							nxt.travel_dir = eoc_pkg::DIR_STOP;
							nxt.prev_dir   = eoc_pkg::DIR_STOP;
							nxt.motor      = eoc_pkg::DIR_STOP;
							nxt.mode       = eoc_pkg::MODE_SERVE_HOLD;
							nxt.hold_count = hold_ticks;
							door   = 1'b1;
							served = 1'b1;
						end else if (nxt.recent_floor == eoc_pkg::FLOOR_W'(f) && nxt.emergency) begin
							// emergency reversal away from the last direction
							if (nxt.prev_dir == eoc_pkg::DIR_UP) begin
								nxt.travel_dir = eoc_pkg::DIR_DOWN;
								nxt.prev_dir   = eoc_pkg::DIR_DOWN;
								nxt.motor      = eoc_pkg::DIR_DOWN;
								nxt.emergency  = 1'b0;
							end else if (nxt.prev_dir == eoc_pkg::DIR_DOWN) begin
								nxt.travel_dir = eoc_pkg::DIR_UP;
								nxt.prev_dir   = eoc_pkg::DIR_UP;
								nxt.motor      = eoc_pkg::DIR_UP;
								nxt.emergency  = 1'b0;
							end
						end
					end
				end
				if (!served) begin
					if (tick.obstruction) begin
						nxt.mode = eoc_pkg::MODE_OBSTRUCTED;
						door  = 1'b1;
						slamp = 1'b1;
					end else if (tick.stop_button) begin
						nxt.mode       = eoc_pkg::MODE_STOPPED;
						nxt.travel_dir = eoc_pkg::DIR_STOP;
						nxt.emergency  = 1'b1;
						nxt.motor      = eoc_pkg::DIR_STOP;
						nxt.pending    = '0;
						slamp = 1'b1;
						door  = seen;
					end
				end
			end
		endcase

		res.motor_command   = nxt.motor;
		res.button_lamps    = nxt.pending;
		res.door_lamp       = door;
		res.stop_lamp       = slamp;
		res.floor_indicator = nxt.recent_floor;
	end

endmodule
`default_nettype wire

>>> src/elevator_order_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_order_controller
// Polling-tick elevator controller with an input register and a result
// register around combinational tick logic.
// ----------------------------------------------------------------------------
// usage
//   s_* carries one polling tick per transaction (sensor, buttons, switches);
//   m_* returns one result transaction per tick (motor, lamps, indicator).
//   cfg_wr_en/cfg_wr_data write the door hold length in ticks; write only
//   while no tick is in flight.
// pipeline and throughput
//   a tick is held in the input register, then processed into the result
//   register on m_*. One tick per cycle is sustained while m_tready is
//   high; the floor scan is a four-step priority chain in the tick logic.
// reset
//   arst_n clears the controller to homing mode (motor up, no orders, door
//   hold 100) and empties both registers.
// stall
//   while m_tready is low the result holds; one more tick waits in the input
//   register, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module elevator_order_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	// door hold length
	input  logic                        cfg_wr_en,
	input  logic [eoc_pkg::HOLD_W-1:0]  cfg_wr_data,
	// tick input
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// at_floor[0], floor_index[2:1], call_buttons[14:3], obstruction[15],
	// stop_button[16], zero[23:17]
	input  logic [23:0]                 s_tdata,
	// result output
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// motor_command[1:0], button_lamps[13:2], door_lamp[14], stop_lamp[15],
	// floor_indicator[17:16], zero[23:18]
	output logic [23:0]                 m_tdata
);

	logic [eoc_pkg::HOLD_W-1:0]    door_hold_q;
	logic                          valid_s1;
	eoc_pkg::tick_t                tick_s1;
	eoc_pkg::ctrl_state_t          state_q;
	eoc_pkg::ctrl_state_t          state_nxt;
	eoc_pkg::result_t              res_nxt;
	eoc_pkg::result_t              res_s2;
	logic                          valid_s2;
	logic                          advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_hold_q <= eoc_pkg::HOLD_RESET;
		end else if (cfg_wr_en) begin
			door_hold_q <= cfg_wr_data;
		end
	end

	// handshake: the tick moves on when the result slot is free or leaving
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.at_floor     <= s_tdata[0];
			tick_s1.floor_index  <= s_tdata[2:1];
			tick_s1.call_buttons <= s_tdata[14:3];
			tick_s1.obstruction  <= s_tdata[15];
			tick_s1.stop_button  <= s_tdata[16];
		end
	end

	// tick logic
	eoc_step u_step (
		.cur        (state_q),
		.tick       (tick_s1),
		.hold_ticks (door_hold_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pending      <= '0;
			state_q.recent_floor <= '0;
			state_q.travel_dir   <= eoc_pkg::DIR_STOP;
			state_q.prev_dir     <= eoc_pkg::DIR_STOP;
			state_q.motor        <= eoc_pkg::DIR_UP;
			state_q.emergency    <= 1'b0;
			state_q.mode         <= eoc_pkg::MODE_HOMING;
			state_q.hold_count   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.floor_indicator, res_s2.stop_lamp, res_s2.door_lamp,
		res_s2.button_lamps, res_s2.motor_command};

endmodule
`default_nettype wire

>>> src/eoc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eoc_checker
// Port-level checks of the elevator order controller, bound to the top level.
// ----------------------------------------------------------------------------
module eoc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [eoc_pkg::HOLD_W-1:0]  cfg_wr_data,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [23:0]                 s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [23:0]                 m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted tick shows up once the result slot can move
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (m_tready || !m_tvalid) |=> m_tvalid)
		else $error("accepted tick did not produce a result");

	// stopped between floors: no orders kept
	a_stop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] && !m_tdata[14] |-> m_tdata[13:2] == 12'd0)
		else $error("orders kept while stopped");

	// stopped between floors: motor off
	a_stop_motor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] && !m_tdata[14] |-> m_tdata[1:0] == eoc_pkg::DIR_STOP)
		else $error("motor running while stopped");

endmodule

bind elevator_order_controller eoc_checker u_eoc_checker (.*);
`default_nettype wire
